// ===== design/gb18030_glyph_index_decoder_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef GB18030_GLYPH_INDEX_DECODER_UNIT_MACROS_SVH
`define GB18030_GLYPH_INDEX_DECODER_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define GBD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gbd assertion failed");

// Check a property on every rising edge, reset included.
`define GBD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gbd assertion failed");

`endif

// ===== design/gbd_pkg.sv =====
package gbd_pkg;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 15;
   localparam int ADDR_W  = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LANGUAGE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_SELECT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDR_LARGE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDR_SMALL = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic              language_mode;
      logic              font_select;
      logic [ADDR_W-1:0] base_addr_large;
      logic [ADDR_W-1:0] base_addr_small;
   } cfg_type;

   typedef struct packed {
      logic              glyph;
      logic              four;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      logic [BYTE_W-1:0] b3;
      logic              last;
   } cmd_type;

endpackage

// ===== design/gbd_front.sv =====
module gbd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  gbd_pkg::cfg_type       cfg,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_in_byte,
   output logic                   q_push,
   input  logic                   q_full,
   output gbd_pkg::cmd_type       q_data
);
   import gbd_pkg::*;

   typedef enum logic [1:0] {
      TAIL_NONE   = 2'd0,
      TAIL_SINGLE = 2'd1,
      TAIL_GLYPH  = 2'd2
   } tail_type;

   logic [BYTE_W-1:0] h1_ff, h2_ff, h3_ff;
   logic [BYTE_W-1:0] h1_in, h2_in, h3_in;
   logic [1:0]        hc_ff, hc_in;
   cmd_type           pend_ff [4];
   cmd_type           pend_in [4];
   logic [2:0]        cnt_ff, cnt_in;

   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] held [3];
   logic              is_lead, two_ok, digit, reparse, four, accept, drain;
   logic [1:0]        flush_n;
   logic [2:0]        n;
   tail_type          tail;
   cmd_type           glyph_cmd;

   assign b       = req_in_byte;
   assign held[0] = h1_ff;
   assign held[1] = h2_ff;
   assign held[2] = h3_ff;
   assign is_lead = (b >= 8'h81) && (b <= 8'hFE);
   assign two_ok  = ((b >= 8'h40) && (b <= 8'h7E)) || ((b >= 8'h80) && (b <= 8'hFE));
   assign digit   = (b >= 8'h30) && (b <= 8'h39);

   assign drain    = (cnt_ff != 3'd0) && !q_full;
   assign q_push   = drain;
   assign q_data   = pend_ff[0];
   assign req_full = (cnt_ff > 3'd1) || ((cnt_ff == 3'd1) && q_full);
   assign accept   = req_push && !req_full;

   always_comb begin
      flush_n = 2'd0;
      tail    = TAIL_NONE;
      four    = 1'b0;
      reparse = 1'b0;
      hc_in   = 2'd0;
      h1_in   = h1_ff;
      h2_in   = h2_ff;
      h3_in   = h3_ff;
      if (!cfg.language_mode) begin
         flush_n = hc_ff;
         tail    = TAIL_SINGLE;
      end else begin
         unique case (hc_ff)
            2'd0: reparse = 1'b1;
            2'd1: begin
               if (two_ok) begin
                  tail = TAIL_GLYPH;
               end else if (digit) begin
                  h2_in = b;
                  hc_in = 2'd2;
               end else begin
                  flush_n = 2'd1;
                  reparse = 1'b1;
               end
            end
            2'd2: begin
               if (is_lead) begin
                  h3_in = b;
                  hc_in = 2'd3;
               end else begin
                  flush_n = 2'd2;
                  reparse = 1'b1;
               end
            end
            2'd3: begin
               if (digit) begin
                  tail = TAIL_GLYPH;
                  four = 1'b1;
               end else begin
                  flush_n = 2'd3;
                  reparse = 1'b1;
               end
            end
         endcase
      end
      if (reparse) begin
         if (is_lead) begin
            h1_in = b;
            hc_in = 2'd1;
         end else begin
            tail = TAIL_SINGLE;
         end
      end
   end

   assign n = {1'b0, flush_n} + ((tail != TAIL_NONE) ? 3'd1 : 3'd0);

   always_comb begin
      glyph_cmd       = '0;
      glyph_cmd.glyph = 1'b1;
      glyph_cmd.four  = four;
      glyph_cmd.b0    = h1_ff;
      glyph_cmd.b1    = four ? h2_ff : b;
      glyph_cmd.b2    = h3_ff;
      glyph_cmd.b3    = b;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pend_in[i] = '0;
         if (accept) begin
            if (i < int'(flush_n)) begin
               pend_in[i].b0 = held[i % 3];
            end else if ((i == int'(flush_n)) && (tail == TAIL_GLYPH)) begin
               pend_in[i] = glyph_cmd;
            end else begin
               pend_in[i].b0 = b;
            end
            pend_in[i].last = (3'(i) == (n - 3'd1));
         end else if (drain && (i < 3)) begin
            pend_in[i] = pend_ff[(i + 1) % 4];
         end else begin
            pend_in[i] = pend_ff[i];
         end
      end
   end

   always_comb begin
      if (accept) begin
         cnt_in = n;
      end else if (drain) begin
         cnt_in = cnt_ff - 3'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         hc_ff  <= 2'd0;
         h1_ff  <= '0;
         h2_ff  <= '0;
         h3_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            hc_ff <= hc_in;
            h1_ff <= h1_in;
            h2_ff <= h2_in;
            h3_ff <= h3_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

// ===== design/gbd_queue.sv =====
module gbd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  gbd_pkg::cmd_type push_data,
   input  logic             pop,
   output logic             empty,
   output gbd_pkg::cmd_type pop_data
);
   import gbd_pkg::*;

   cmd_type                store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ff];
   assign wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== design/gbd_back.sv =====
module gbd_back #(
   parameter int GLYPH_BYTES_LARGE = 72,
   parameter int GLYPH_BYTES_SMALL = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbd_pkg::cfg_type       cfg,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  gbd_pkg::cmd_type       q_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_char_code,
   output logic [14:0]            rsp_glyph_index,
   output logic [23:0]            rsp_glyph_addr,
   output logic                   rsp_last
);
   import gbd_pkg::*;

   localparam int SIZE_MAX = (GLYPH_BYTES_LARGE > GLYPH_BYTES_SMALL) ?
                             GLYPH_BYTES_LARGE : GLYPH_BYTES_SMALL;
   localparam int SIZE_W   = $clog2(SIZE_MAX + 1);
   localparam int PROD_W   = INDEX_W + SIZE_W;

   function automatic logic [INDEX_W-1:0] index_two(logic [7:0] c1, logic [7:0] c2);
      logic [15:0] a2;
      logic [15:0] r;
      a2 = (c2 > 8'h7F) ? 16'(c2) - 16'd1 : 16'(c2);
      if ((c1 >= 8'hA1) && (c1 <= 8'hA9) && (c2 >= 8'hA1)) begin
         r = (16'(c1) - 16'hA1) * 16'd94 + (16'(c2) - 16'hA1);
      end else if ((c1 >= 8'hA8) && (c1 <= 8'hA9) && (c2 < 8'hA1)) begin
         r = (16'(c1) - 16'hA8) * 16'd96 + (a2 - 16'h40) + 16'd846;
      end else if ((c1 >= 8'hB0) && (c1 <= 8'hF7) && (c2 >= 8'hA1)) begin
         r = (16'(c1) - 16'hB0) * 16'd94 + (16'(c2) - 16'hA1) + 16'd1038;
      end else if ((c1 >= 8'h81) && (c1 <= 8'hA0)) begin
         r = (16'(c1) - 16'h81) * 16'd190 + (a2 - 16'h40) + 16'd7806;
      end else if ((c1 >= 8'hAA) && (c2 < 8'hA1)) begin
         r = (16'(c1) - 16'hAA) * 16'd96 + (a2 - 16'h40) + 16'd13886;
      end else begin
         r = '0;
      end
      return r[INDEX_W-1:0];
   endfunction

   function automatic logic [INDEX_W-1:0] index_four(logic [7:0] c1, logic [7:0] c2,
                                                     logic [7:0] c3, logic [7:0] c4);
      logic [15:0] r;
      if ((c1 == 8'h81) && (c2 == 8'h39) && (c3 == 8'hEE) && (c4 == 8'h39)) begin
         r = 16'd22046;
      end else if ((c1 == 8'h81) && (c2 == 8'h39) && (c3 >= 8'hEF)) begin
         r = (16'(c3) - 16'hEF) * 16'd10 + (16'(c4) - 16'h30) + 16'd22047;
      end else if ((c1 == 8'h82) && (((c2 >= 8'h30) && (c2 <= 8'h34) && (c3 >= 8'h81)
                   && (c3 <= 8'hFE)) || ((c2 == 8'h35) && (c3 >= 8'h81)
                   && (c3 <= 8'h87)))) begin
         r = (16'(c2) - 16'h30) * 16'd1260 + (16'(c3) - 16'h81) * 16'd10
             + (16'(c4) - 16'h30) + 16'd22207;
      end else begin
         r = '0;
      end
      return r[INDEX_W-1:0];
   endfunction

   logic               a_valid_ff, a_valid_in;
   logic               a_kind_ff;
   logic [7:0]         a_char_ff;
   logic [INDEX_W-1:0] a_idx_ff, a_idx_in;
   logic               a_last_ff;
   logic               b_valid_ff, b_valid_in;
   logic               b_kind_ff;
   logic [7:0]         b_char_ff;
   logic [INDEX_W-1:0] b_idx_ff;
   logic [ADDR_W-1:0]  b_addr_ff, b_addr_in;
   logic               b_last_ff;
   logic               a_adv, b_adv;
   logic [SIZE_W-1:0]  size;
   logic [ADDR_W-1:0]  base;
   logic [PROD_W-1:0]  prod;

   assign b_adv      = !b_valid_ff || rsp_pop;
   assign a_adv      = !a_valid_ff || b_adv;
   assign q_pop      = a_adv && !q_empty;
   assign a_valid_in = a_adv ? !q_empty : a_valid_ff;
   assign b_valid_in = b_adv ? a_valid_ff : b_valid_ff;

   assign a_idx_in = !q_data.glyph ? '0 :
                     q_data.four   ? index_four(q_data.b0, q_data.b1, q_data.b2, q_data.b3) :
                                     index_two(q_data.b0, q_data.b1);

   assign size = cfg.font_select ? SIZE_W'(GLYPH_BYTES_SMALL) : SIZE_W'(GLYPH_BYTES_LARGE);
   assign base = cfg.font_select ? cfg.base_addr_small : cfg.base_addr_large;
   assign prod = PROD_W'(a_idx_ff) * PROD_W'(size);
   assign b_addr_in = a_kind_ff ? base + ADDR_W'(prod) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_kind_ff <= q_data.glyph;
         a_char_ff <= q_data.glyph ? 8'd0 : q_data.b0;
         a_idx_ff  <= a_idx_in;
         a_last_ff <= q_data.last;
      end
      if (b_adv && a_valid_ff) begin
         b_kind_ff <= a_kind_ff;
         b_char_ff <= a_char_ff;
         b_idx_ff  <= a_idx_ff;
         b_addr_ff <= b_addr_in;
         b_last_ff <= a_last_ff;
      end
   end

   assign rsp_empty       = !b_valid_ff;
   assign rsp_kind        = b_kind_ff;
   assign rsp_char_code   = b_char_ff;
   assign rsp_glyph_index = b_idx_ff;
   assign rsp_glyph_addr  = b_addr_ff;
   assign rsp_last        = b_last_ff;

endmodule

// ===== design/gb18030_glyph_index_decoder_unit.sv =====
// GB18030 byte stream decoder with glyph index and font store addressing.
// Request side: a queue-style push port. A byte is taken when req_push is
//   high and req_full is low.
// Response side: a queue-style pop port. The oldest word sits on the rsp_
//   ports while rsp_empty is low and leaves when rsp_pop is high.
// Register port: csr_valid/csr_ready with csr_index 0..3 (language mode,
//   font select, large font base, small font base); csr_ready is always high.
// Path: a word goes from the front-end pending register through the command
//   queue and the index and address stages to the response ports.
// Throughput: a byte holds the front end until the words it causes, up to
//   four, are written out. The front end writes one word a cycle while the
//   four-entry command queue has room; the back end decodes one word a cycle
//   through index and address stages unless a response waits for rsp_pop.
// Reset clears the registers, the held partial code and all queues.
// When rsp_pop stays low the back end holds its stages, the command queue
//   fills and req_full rises; no word is lost or repeated.
module gb18030_glyph_index_decoder_unit #(
   parameter int GLYPH_BYTES_LARGE = 72,
   parameter int GLYPH_BYTES_SMALL = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_char_code,
   output logic [14:0] rsp_glyph_index,
   output logic [23:0] rsp_glyph_addr,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import gbd_pkg::*;

   cfg_type cfg_ff;
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LANGUAGE_MODE:   cfg_ff.language_mode   <= csr_data[0];
            CSR_FONT_SELECT:     cfg_ff.font_select     <= csr_data[0];
            CSR_BASE_ADDR_LARGE: cfg_ff.base_addr_large <= csr_data;
            CSR_BASE_ADDR_SMALL: cfg_ff.base_addr_small <= csr_data;
         endcase
      end
   end

   gbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .q_push      (q_push),
      .q_full      (q_full),
      .q_data      (q_wdata)
   );

   gbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_wdata),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   gbd_back #(
      .GLYPH_BYTES_LARGE (GLYPH_BYTES_LARGE),
      .GLYPH_BYTES_SMALL (GLYPH_BYTES_SMALL)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_data          (q_rdata),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_char_code   (rsp_char_code),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_glyph_addr  (rsp_glyph_addr),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== design/gbd_checker.sv =====
`include "gb18030_glyph_index_decoder_unit_macros.svh"

module gbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_kind,
   input logic [7:0]  rsp_char_code,
   input logic [14:0] rsp_glyph_index,
   input logic [23:0] rsp_glyph_addr,
   input logic        rsp_last
);

   `GBD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty && !req_full)
   `GBD_ASSERT(a_single_clean, clock, reset,
      (!rsp_empty && !rsp_kind) |-> (rsp_glyph_index == 15'd0) && (rsp_glyph_addr == 24'd0))
   `GBD_ASSERT(a_glyph_clean, clock, reset, (!rsp_empty && rsp_kind) |-> (rsp_char_code == 8'd0))
   `GBD_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_glyph_addr) && $stable(rsp_last))

endmodule

bind gb18030_glyph_index_decoder_unit gbd_checker u_gbd_checker (.*);
